### src/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_NR(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NR(label, prop, msg)
`endif

`endif

### src/nfba_pkg.sv
// Shared types and constants for the next-fit bitmap allocator.
// No dependencies.
package nfba_pkg;

	localparam int NUM_ENTRIES = 16384;
	localparam int WORD_W      = 64;
	localparam int ROWS        = NUM_ENTRIES / WORD_W;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BADFREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE
	} state_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [IDX_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_index;
		logic [CNT_W-1:0] free_entries;
	} rsp_t;

endpackage

### src/next_fit_bitmap_allocator_unit.sv
// Next-fit bitmap allocator: 16384 used bits kept as 256 words of 64 in one RAM.
// Allocate: the scan reads one map word per cycle, from the start word over the rows in
// use and back to the start word. Allocate with no free entries and free out of range
// finish without reading the map. Free reads the map word, then writes it back. One request
// at a time; busy drops in the cycle the result strobes. Results cannot be stalled.
// Reset and every pool-size write (cfg_we) clear the map at once through per-word valid bits.
`include "assert_macros.svh"

module next_fit_bitmap_allocator_unit
	import nfba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             req,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] free_q;
	logic [IDX_W-1:0] start_q;
	logic [ROWS-1:0]  vld_q;
	logic             done_q;
	rsp_t             rsp_q;

	// scan bookkeeping
	logic [BIT_W-1:0] p_bit_q;
	logic [ROW_W-1:0] iss_row_q;
	logic [ROW_W:0]   iss_k_q;
	logic [IDX_W-1:0] fidx_q;

	// stage 1: what the RAM read returning this cycle belongs to
	logic             chk_on_s1;
	logic             chk_first_s1;
	logic             chk_last_s1;
	logic [ROW_W-1:0] chk_row_s1;
	logic             vld_s1;

	logic             ram_we, ram_re;
	logic [ROW_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic             acc;
	logic [CNT_W-1:0] n_m1;
	logic [ROW_W-1:0] nrows_m1;
	logic [ROW_W:0]   nrows;
	logic [BIT_W-1:0] lim_bit;
	logic [CNT_W-1:0] ss1;
	logic [IDX_W-1:0] p;
	logic [WORD_W-1:0] word, cand;
	logic             hit;
	logic [BIT_W-1:0] hit_bit;
	logic             free_bit_set;
	logic [CNT_W-1:0] cfg_sat;

	function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, BIT_W'(i)};
			end
		end
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
	                                               input logic [ROW_W-1:0] last);
		logic [ROW_W-1:0] nr;
		nr = (r == last) ? '0 : ROW_W'(r + 1'b1);
		return nr;
	endfunction

	assign acc      = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign result   = rsp_q;

	assign n_m1     = n_q - 1'b1;
	assign nrows_m1 = n_m1[IDX_W-1:BIT_W];
	assign nrows    = {1'b0, nrows_m1} + 1'b1;
	assign lim_bit  = n_m1[BIT_W-1:0];

	// next-fit start: entry after the last grant, wrapping at the pool size
	assign ss1 = {1'b0, start_q} + 1'b1;
	assign p   = (ss1 >= n_q) ? '0 : ss1[IDX_W-1:0];

	assign word = vld_s1 ? ram_rdata : '0;

	always_comb begin
		logic [WORD_W-1:0] m;
		logic [BIT_W:0]    fs;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = 1'b1;
			if (chk_first_s1 && (BIT_W'(i) < p_bit_q)) begin
				m[i] = 1'b0;
			end
			// the start word comes back last with only the bits before the start point
			if (chk_last_s1 && (BIT_W'(i) >= p_bit_q)) begin
				m[i] = 1'b0;
			end
			if ((chk_row_s1 == nrows_m1) && (BIT_W'(i) > lim_bit)) begin
				m[i] = 1'b0;
			end
		end
		cand    = ~word & m;
		fs      = first_set(cand);
		hit     = fs[BIT_W];
		hit_bit = fs[BIT_W-1:0];
	end

	assign free_bit_set = word[fidx_q[BIT_W-1:0]];

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_sat = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(NUM_ENTRIES)) begin
			cfg_sat = CNT_W'(NUM_ENTRIES);
		end else begin
			cfg_sat = cfg_wdata;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = iss_row_q;
		ram_we    = 1'b0;
		ram_waddr = chk_row_s1;
		ram_wdata = word;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.cmd == CMD_ALLOC) begin
						if (free_q != '0) begin
							ram_re    = 1'b1;
							ram_raddr = p[IDX_W-1:BIT_W];
							state_d   = S_SCAN;
						end
					end else if ({1'b0, req.entry_index} < n_q) begin
						ram_re    = 1'b1;
						ram_raddr = req.entry_index[IDX_W-1:BIT_W];
						state_d   = S_FREE;
					end
				end
			end
			S_SCAN: begin
				ram_re = (iss_k_q <= nrows);
				if (chk_on_s1) begin
					if (hit) begin
						ram_we    = 1'b1;
						ram_wdata = word | (WORD_W'(1) << hit_bit);
						state_d   = S_IDLE;
					end else if (chk_last_s1) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FREE: begin
				ram_waddr = fidx_q[IDX_W-1:BIT_W];
				if (free_bit_set) begin
					ram_we    = 1'b1;
					ram_wdata = word & ~(WORD_W'(1) << fidx_q[BIT_W-1:0]);
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= CNT_W'(NUM_ENTRIES);
			free_q    <= CNT_W'(NUM_ENTRIES);
			start_q   <= '0;
			vld_q     <= '0;
			done_q    <= 1'b0;
			chk_on_s1 <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			chk_on_s1 <= ram_re && (state_d == S_SCAN);
			if (cfg_we) begin
				n_q     <= cfg_sat;
				free_q  <= cfg_sat;
				start_q <= '0;
				vld_q   <= '0;
			end else begin
				if (ram_we) begin
					vld_q[ram_waddr] <= 1'b1;
				end
				case (state_q)
					S_IDLE: begin
						if (acc && (state_d == S_IDLE)) begin
							done_q <= 1'b1;
						end
					end
					S_SCAN: begin
						if (chk_on_s1 && hit) begin
							done_q  <= 1'b1;
							free_q  <= free_q - 1'b1;
							start_q <= {chk_row_s1, hit_bit};
						end else if (chk_on_s1 && chk_last_s1) begin
							done_q <= 1'b1;
						end
					end
					S_FREE: begin
						done_q <= 1'b1;
						if (free_bit_set && (free_q < n_q)) begin
							free_q <= free_q + 1'b1;
						end
					end
					default: begin
						done_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// payload and scan tags: no reset needed
	always_ff @(posedge clk) begin
		if (ram_re) begin
			vld_s1     <= vld_q[ram_raddr];
			chk_row_s1 <= ram_raddr;
		end
		case (state_q)
			S_IDLE: begin
				chk_first_s1 <= 1'b1;
				chk_last_s1  <= 1'b0;
				p_bit_q      <= p[BIT_W-1:0];
				iss_row_q    <= next_row(p[IDX_W-1:BIT_W], nrows_m1);
				iss_k_q      <= (ROW_W+1)'(1);
				fidx_q       <= req.entry_index;
				rsp_q.granted_index <= '0;
				rsp_q.free_entries  <= free_q;
				rsp_q.status <= (req.cmd == CMD_ALLOC) ? STAT_FULL : STAT_BADFREE;
			end
			S_SCAN: begin
				chk_first_s1 <= 1'b0;
				chk_last_s1  <= (iss_k_q == nrows);
				if (ram_re) begin
					iss_row_q <= next_row(iss_row_q, nrows_m1);
					iss_k_q   <= iss_k_q + 1'b1;
				end
				if (hit) begin
					rsp_q.status        <= STAT_DONE;
					rsp_q.granted_index <= {chk_row_s1, hit_bit};
					rsp_q.free_entries  <= free_q - 1'b1;
				end else begin
					rsp_q.status        <= STAT_FULL;
					rsp_q.granted_index <= '0;
					rsp_q.free_entries  <= free_q;
				end
			end
			S_FREE: begin
				rsp_q.granted_index <= '0;
				if (free_bit_set) begin
					rsp_q.status       <= STAT_DONE;
					rsp_q.free_entries <= (free_q < n_q) ? CNT_W'(free_q + 1'b1) : free_q;
				end else begin
					rsp_q.status       <= STAT_BADFREE;
					rsp_q.free_entries <= free_q;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	nfba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`ASSERT_NR(a_done_when_idle, done_q |-> (state_q == S_IDLE), "result strobed while busy")
	`ASSERT_CLK(a_free_le_pool, free_q <= n_q, "free count above pool size")
	`ASSERT_CLK(a_fail_no_grant, (done_q && (rsp_q.status != STAT_DONE)) |-> (rsp_q.granted_index == '0), "failed request reports a grant")
	`ASSERT_CLK(a_write_busy, ram_we |-> (state_q != S_IDLE), "map written while idle")
	`ASSERT_CLK(a_grant_in_pool, (done_q && (rsp_q.granted_index != '0)) |-> ({1'b0, rsp_q.granted_index} < n_q), "grant beyond pool")

endmodule

### src/nfba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module nfba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### test/tb_next_fit_bitmap_allocator_unit.sv
// Self-checking testbench for next_fit_bitmap_allocator_unit: directed table, then random
// alloc/free traffic over several pool sizes, checked against an in-bench predictor.
// Depends on nfba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_next_fit_bitmap_allocator_unit;
	import nfba_pkg::*;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int DRAIN_CYCLES = 270;
	localparam int NUM_PHASES   = 10;
	localparam int PHASE_ITEMS  = 68;
	localparam int NUM_ROWS     = 23;

	typedef struct packed {
		logic             is_cfg;
		logic [CNT_W-1:0] value;    // pool size on config rows, entry index on requests
		cmd_t             cmd;
		logic             typed;
		status_t          st;
		logic [IDX_W-1:0] gnt;
		logic [CNT_W-1:0] cnt;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             result;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	// predictor state
	bit               used_map [NUM_ENTRIES];
	int               scan_start;
	int               free_count;
	int               pool_size;

	rsp_t             expected_grants [$];
	int               live_entries [$];
	int               mismatch_count;

	row_t             dir_rows [NUM_ROWS];
	logic [CNT_W-1:0] phase_sizes [NUM_PHASES];

	next_fit_bitmap_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(4 * LIMIT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	function automatic void pool_reset(input logic [CNT_W-1:0] v);
		int n;
		n = int'(v);
		if (n < 1)
			n = 1;
		if (n > NUM_ENTRIES)
			n = NUM_ENTRIES;
		pool_size = n;
		foreach (used_map[i])
			used_map[i] = 1'b0;
		scan_start = 0;
		free_count = n;
	endfunction

	function automatic rsp_t predict_grant(input req_t r);
		rsp_t o;
		int   pos;
		o.status        = STAT_DONE;
		o.granted_index = '0;
		if (r.cmd == CMD_ALLOC) begin
			o.status = STAT_FULL;
			if (free_count != 0) begin
				// next-fit: start one past the last grant, scan_start itself is tried last
				pos = scan_start + 1;
				if (pos >= pool_size)
					pos = 0;
				for (int k = 0; k < pool_size; k++) begin
					if (!used_map[pos]) begin
						used_map[pos]   = 1'b1;
						scan_start      = pos;
						free_count      = free_count - 1;
						o.granted_index = IDX_W'(pos);
						o.status        = STAT_DONE;
						break;
					end
					pos = pos + 1;
					if (pos >= pool_size)
						pos = 0;
				end
			end
		end else if (r.entry_index >= pool_size || !used_map[r.entry_index]) begin
			o.status = STAT_BADFREE;
		end else begin
			used_map[r.entry_index] = 1'b0;
			if (free_count < pool_size)
				free_count = free_count + 1;
		end
		o.free_entries = CNT_W'(free_count);
		return o;
	endfunction

	function automatic int pick_gap(input bit burst);
		int p;
		p = $urandom_range(99);
		if (burst || p < 60)
			return 0;
		if (p < 93)
			return $urandom_range(3, 1);
		return $urandom_range(60, 15);
	endfunction

	task automatic wait_for_results();
		while (expected_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic issue(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t pred;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// request taken at this edge
		pred = predict_grant(r);
		expected_grants.push_back(typed ? typed_rsp : pred);
		if (r.cmd == CMD_ALLOC && pred.status == STAT_DONE) begin
			live_entries.push_back(int'(pred.granted_index));
		end else if (r.cmd == CMD_FREE && pred.status == STAT_DONE) begin
			for (int j = 0; j < live_entries.size(); j++) begin
				if (live_entries[j] == r.entry_index) begin
					live_entries.delete(j);
					break;
				end
			end
		end
	endtask

	task automatic idle_for(input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_pool_size(input logic [CNT_W-1:0] v);
		start <= 1'b0;
		wait_for_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pool_reset(v);
		live_entries.delete();
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_grants.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("unexpected result: status=%0d granted=%0d free=%0d",
						result.status, result.granted_index, result.free_entries);
			end else begin
				e = expected_grants.pop_front();
				if (result.status !== e.status || result.granted_index !== e.granted_index
						|| result.free_entries !== e.free_entries) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("mismatch: expected status=%0d granted=%0d free=%0d, got status=%0d granted=%0d free=%0d",
							e.status, e.granted_index, e.free_entries,
							result.status, result.granted_index, result.free_entries);
				end
			end
		end
	end

	initial begin
		row_t   row;
		req_t   r;
		rsp_t   t;
		int     alloc_pct;
		int     sel;
		bit     burst;

		mismatch_count = 0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		pool_reset(CNT_W'(NUM_ENTRIES));

		dir_rows = '{
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd1, 15'd16383},
			'{1'b0, 15'd16383, CMD_ALLOC, 1'b1, STAT_DONE,    14'd2, 15'd16382},
			'{1'b0, 15'd1,     CMD_FREE,  1'b1, STAT_DONE,    14'd0, 15'd16383},
			'{1'b0, 15'd1,     CMD_FREE,  1'b1, STAT_BADFREE, 14'd0, 15'd16383},
			'{1'b0, 15'd16383, CMD_FREE,  1'b1, STAT_BADFREE, 14'd0, 15'd16383},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0},
			'{1'b1, 15'd32767, CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd1, 15'd16383},
			'{1'b1, 15'd0,     CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_FULL,    14'd0, 15'd0},
			'{1'b0, 15'd1,     CMD_FREE,  1'b1, STAT_BADFREE, 14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_FREE,  1'b1, STAT_DONE,    14'd0, 15'd1},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd0, 15'd0},
			'{1'b1, 15'd3,     CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd1, 15'd2},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd2, 15'd1},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b1, STAT_FULL,    14'd0, 15'd0},
			'{1'b0, 15'd2,     CMD_FREE,  1'b1, STAT_DONE,    14'd0, 15'd1},
			'{1'b0, 15'd0,     CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0},
			'{1'b0, 15'd3,     CMD_FREE,  1'b1, STAT_BADFREE, 14'd0, 15'd0},
			'{1'b1, 15'd16384, CMD_ALLOC, 1'b0, STAT_DONE,    14'd0, 15'd0}
		};
		phase_sizes = '{15'd16384, 15'd8, 15'd65, 15'd1, 15'd100,
			15'd64, 15'd2, 15'd5000, 15'd16385, 15'd16384};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				write_pool_size(row.value);
			end else begin
				r.cmd           = row.cmd;
				r.entry_index   = row.value[IDX_W-1:0];
				t.status        = row.st;
				t.granted_index = row.gnt;
				t.free_entries  = row.cnt;
				issue(r, row.typed, t);
				idle_for(pick_gap(1'b0));
			end
		end

		// random traffic, one pool size per phase; each size change drains first
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_pool_size(phase_sizes[p]);
			alloc_pct = (p % 2) ? 75 : 50;
			burst     = (p % 3 == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r.cmd         = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
				r.entry_index = IDX_W'($urandom_range(NUM_ENTRIES - 1));
				if (r.cmd == CMD_FREE) begin
					sel = $urandom_range(99);
					if (sel < 70 && live_entries.size() != 0)
						r.entry_index = IDX_W'(live_entries[$urandom_range(live_entries.size() - 1)]);
					else if (sel < 90)
						r.entry_index = IDX_W'($urandom_range(pool_size - 1));
				end
				issue(r, 1'b0, '0);
				idle_for(pick_gap(burst));
			end
		end

		start <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_grants.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/nfba_pkg.sv
src/nfba_ram.sv
src/next_fit_bitmap_allocator_unit.sv
test/tb_next_fit_bitmap_allocator_unit.sv
